@@ hw/rtl/range_split_across_partitions_assert.svh @@
// ----------------------------------------------------------------------------
// Range split across partitions: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RANGE_SPLIT_ACROSS_PARTITIONS_ASSERT_SVH
`define RANGE_SPLIT_ACROSS_PARTITIONS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSAP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSAP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rsap_pkg.sv @@
// ----------------------------------------------------------------------------
// Range split across partitions: package
// Field widths, item types and the table depth shared by the front end, back end and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rsap_pkg;

   localparam int MAX_PARTS_DEFAULT = 16;
   localparam int TABLE_LIMIT       = 16;

   localparam int CNT_W  = 5;
   localparam int ID_W   = 4;
   localparam int VAL_W  = 31;
   localparam int END_W  = 32;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 72;

   // Register index of part_count on the configuration port.
   localparam logic REG_PART_COUNT = 1'b0;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_RANGE = 1'b1
   } req_kind_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      req_kind_type      kind;
      logic              load_ok;
      logic [ID_W-1:0]   entry_index;
      logic [VAL_W-1:0]  boundary_value;
      logic [VAL_W-1:0]  range_offset;
      logic [END_W-1:0]  range_end;
   } work_type;

   typedef struct packed {
      logic [ID_W-1:0]   part_id;
      logic [VAL_W-1:0]  local_offset;
      logic [VAL_W-1:0]  segment_size;
      logic              has_segment;
      logic              last;
      logic              ended;
   } result_type;

   typedef struct packed {
      logic busy;
      logic pend_valid;
      logic pend_ended;
   } back_status_type;

   function automatic int table_depth(input int max_parts);
      return (max_parts < TABLE_LIMIT) ? max_parts : TABLE_LIMIT;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rsap_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsap_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rsap_front.sv @@
// ----------------------------------------------------------------------------
// Range split across partitions: front end
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsap_front #(
   parameter int MAX_PARTS = rsap_pkg::MAX_PARTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [rsap_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic                                req_tuser,
   output rsap_pkg::work_type                       q_entry,
   output logic                                     q_valid,
   input  wire logic                                q_pop
);

   localparam int DEPTH = rsap_pkg::table_depth(MAX_PARTS);

   rsap_pkg::work_type entries_ff [2];
   rsap_pkg::work_type entry_in;
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               push;
   logic               pop;

   // Unpack the item and work out what the back end needs up front.
   always_comb begin
      entry_in.kind           = rsap_pkg::req_kind_type'(req_tuser);
      entry_in.entry_index    = req_tdata[3:0];
      entry_in.boundary_value = req_tdata[34:4];
      entry_in.range_offset   = req_tdata[65:35];
      entry_in.load_ok        = rsap_pkg::CNT_W'(req_tdata[3:0])
                                < rsap_pkg::CNT_W'(DEPTH);
      entry_in.range_end      = {1'b0, req_tdata[65:35]} + {1'b0, req_tdata[96:66]};
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_entry    = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rsap_back.sv @@
// ----------------------------------------------------------------------------
// Range split across partitions: back end
// Writes boundary entries and walks the table for range requests, one entry
// per cycle if not stalled, holding one segment back to mark the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module rsap_back #(
   parameter int MAX_PARTS = rsap_pkg::MAX_PARTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [rsap_pkg::CNT_W-1:0]    part_count,
   input  wire rsap_pkg::work_type            q_entry,
   input  wire logic                          q_valid,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output rsap_pkg::result_type               rsp_item,
   output rsap_pkg::back_status_type          status
);

   localparam int DEPTH = rsap_pkg::table_depth(MAX_PARTS);
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = rsap_pkg::CNT_W;
   localparam int VW    = rsap_pkg::VAL_W;
   localparam int EW    = rsap_pkg::END_W;

   localparam rsap_pkg::result_type EMPTY_RESULT = '{
      part_id: '0, local_offset: '0, segment_size: '0,
      has_segment: 1'b0, last: 1'b1, ended: 1'b1
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_PREV,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [IW-1:0]        i0_ff, i0_in;
   logic [IW-1:0]        resume_ff, resume_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [VW-1:0]        start_ff, start_in;
   logic [VW-1:0]        prev_ff, prev_in;
   logic [EW-1:0]        end_ff, end_in;
   logic [EW-1:0]        prev_end_ff, prev_end_in;
   logic                 ended_ff, ended_in;
   rsap_pkg::result_type pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsap_pkg::result_type out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_raddr;
   logic [VW-1:0]        ram_rdata;
   logic [CW-1:0]        used;
   logic [CW-1:0]        last_idx;
   logic                 out_free;
   logic                 hit;
   logic                 fits;

   rsap_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_entry.entry_index[IW-1:0]),
      .wr_data (q_entry.boundary_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign used     = (part_count > CW'(DEPTH)) ? CW'(DEPTH) : part_count;
   assign last_idx = used - CW'(1);
   assign out_free = !out_valid_ff || rsp_tready;
   assign hit      = start_ff < ram_rdata;
   assign fits     = end_ff <= {1'b0, ram_rdata};

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      i0_in         = i0_ff;
      resume_in     = resume_ff;
      n_in          = n_ff;
      start_in      = start_ff;
      prev_in       = prev_ff;
      end_in        = end_ff;
      prev_end_in   = prev_end_ff;
      ended_in      = ended_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_raddr     = cur_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.kind == rsap_pkg::REQ_LOAD) begin
                  ram_we = q_entry.load_ok;
               end else begin
                  n_in        = used;
                  start_in    = q_entry.range_offset;
                  end_in      = q_entry.range_end;
                  prev_end_in = q_entry.range_end;
                  // Resume only when the new range does not go back.
                  i0_in       = ({1'b0, q_entry.range_offset} >= prev_end_ff)
                                ? resume_ff : '0;
                  ram_raddr   = last_idx[IW-1:0];
                  state_in    = ST_LAST;
               end
            end
         end
         ST_LAST: begin
            ended_in = (n_ff != '0) && (end_ff >= {1'b0, ram_rdata});
            if (CW'(i0_ff) >= n_ff) begin
               state_in = ST_FLUSH;
            end else if (i0_ff != '0) begin
               ram_raddr = i0_ff - IW'(1);
               state_in  = ST_PREV;
            end else begin
               prev_in   = '0;
               ram_raddr = i0_ff;
               cur_in    = i0_ff;
               state_in  = ST_WALK;
            end
         end
         ST_PREV: begin
            prev_in   = ram_rdata;
            ram_raddr = i0_ff;
            cur_in    = i0_ff;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            // A new segment can only be taken once the held one can move out.
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_valid_in = 1'b1;
                  end
                  pend_in.part_id      = rsap_pkg::ID_W'(cur_ff);
                  pend_in.local_offset = start_ff - prev_ff;
                  pend_in.segment_size = fits ? VW'(end_ff - {1'b0, start_ff})
                                              : ram_rdata - start_ff;
                  pend_in.has_segment  = 1'b1;
                  pend_in.last         = 1'b0;
                  pend_in.ended        = ended_ff;
                  pend_valid_in        = 1'b1;
               end
               if (hit && fits) begin
                  resume_in = cur_ff;
                  state_in  = ST_FLUSH;
               end else begin
                  if (hit) begin
                     start_in = ram_rdata;
                  end
                  prev_in = ram_rdata;
                  if (CW'(cur_ff) + CW'(1) >= n_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     cur_in    = cur_ff + IW'(1);
                     ram_raddr = cur_ff + IW'(1);
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in = EMPTY_RESULT;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         resume_ff     <= '0;
         prev_end_ff   <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         resume_ff     <= resume_in;
         prev_end_ff   <= prev_end_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      cur_ff   <= cur_in;
      i0_ff    <= i0_in;
      n_ff     <= n_in;
      start_ff <= start_in;
      prev_ff  <= prev_in;
      end_ff   <= end_in;
      ended_ff <= ended_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_item   = out_ff;
   assign status     = '{busy: (state_ff != ST_IDLE), pend_valid: pend_valid_ff,
                         pend_ended: pend_ff.ended};

endmodule

`default_nettype wire

@@ hw/rtl/range_split_across_partitions.sv @@
// ----------------------------------------------------------------------------
// Range split across partitions
// Cuts a global range into per-partition segments over a boundary table.
// ----------------------------------------------------------------------------
// The req channel carries two kinds of item, chosen by req_tuser: a load
// writes one cumulative partition end offset into the table, a range item
// asks for (offset, size) to be split. Every range item gives one or more
// items on the rsp channel, in partition order, with rsp_tlast on the final
// one; an empty answer is a single item with rsp_tuser low.
// The user must set part_count over the csr port only while the block is
// idle; the block does not enforce it. A load is written to the table as
// the back end takes it. A range item reads the last table entry for the
// ended flag, then the entry before the resume point if the walk resumes
// past entry zero, then walks at most 16 entries, one per cycle while the
// output is not stalled, and ends in a flush that offers the final item.
// Items are worked one at a time; a two-entry queue in front lets new items
// be taken during a walk. When rsp_tready is low the walk pauses once a new
// segment is found while one is held and another waits at the output, and
// resumes without loss. Reset empties the queue, drops any item in flight
// and clears part_count, the resume point and the previous end; table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_split_across_partitions_assert.svh"

module range_split_across_partitions #(
   parameter int MAX_PARTS = rsap_pkg::MAX_PARTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: entry_index[3:0], boundary_value[34:4], range_offset[65:35],
   //            range_size[96:66], zero fill [103:97]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rsap_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: req_type[0]
   input  wire logic                              req_tuser,
   // rsp_tdata: part_id[3:0], local_offset[34:4], segment_size[65:35],
   //            ended[66], zero fill [71:67]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [rsap_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: has_segment[0]
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [2:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready
);

   rsap_pkg::work_type              q_entry;
   logic                            q_valid;
   logic                            q_pop;
   rsap_pkg::result_type            rsp_item;
   rsap_pkg::back_status_type       back_status;
   logic [rsap_pkg::CNT_W-1:0]      part_count_ff;
   logic                            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == rsap_pkg::REG_PART_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         part_count_ff <= '0;
      end else if (csr_write) begin
         part_count_ff <= csr_pwdata[rsap_pkg::CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == rsap_pkg::REG_PART_COUNT)
                       ? {{(32 - rsap_pkg::CNT_W){1'b0}}, part_count_ff} : '0;

   rsap_front #(
      .MAX_PARTS (MAX_PARTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_entry    (q_entry),
      .q_valid    (q_valid),
      .q_pop      (q_pop)
   );

   rsap_back #(
      .MAX_PARTS (MAX_PARTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .part_count (part_count_ff),
      .q_entry    (q_entry),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .status     (back_status)
   );

   assign rsp_tdata = {5'b0, rsp_item.ended, rsp_item.segment_size,
                       rsp_item.local_offset, rsp_item.part_id};
   assign rsp_tuser = rsp_item.has_segment;
   assign rsp_tlast = rsp_item.last;

   // An empty answer always closes its request and reports it as ended.
   `RSAP_ASSERT_IMP(a_empty_closes, clock, reset, rsp_tvalid && !rsp_tuser,
                    rsp_tlast && rsp_tdata[66], "empty answer is not last and ended")

   // A held segment only exists while a walk is in progress.
   `RSAP_ASSERT_IMP(a_pend_in_walk, clock, reset, back_status.pend_valid,
                    back_status.busy, "segment held while the back end is idle")

   // Segments of one request carry the same ended flag.
   `RSAP_ASSERT_IMP(a_ended_same, clock, reset,
                    rsp_tvalid && rsp_tuser && !rsp_tlast && back_status.pend_valid,
                    rsp_tdata[66] == back_status.pend_ended,
                    "ended flag differs within one request")

endmodule

`default_nettype wire

@@ test/range_split_across_partitions_test.sv @@
// ----------------------------------------------------------------------------
// Range split across partitions: self-checking testbench
// Loads boundary tables, sends range items under random idling and a long
// receiver hold-off, and checks every result item against a local
// prediction of the partition walk or a typed expectation.
// ----------------------------------------------------------------------------
module range_split_across_partitions_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SETTLE_CYCLES    = 40;
   localparam int          HOLD_CYCLES      = 400;
   localparam int          RANDOM_PER_PHASE = 120;
   localparam logic [30:0] TOP_VALUE        = 31'h7FFF_FFFF;
   localparam logic [2:0]  PART_COUNT_ADDR  = 3'(4 * int'(rsap_pkg::REG_PART_COUNT));

   localparam rsap_pkg::result_type EMPTY_ANSWER = '{part_id: '0, local_offset: '0,
      segment_size: '0, has_segment: 1'b0, last: 1'b1, ended: 1'b1};
   localparam rsap_pkg::result_type FIRST_FIFTY = '{part_id: '0, local_offset: '0,
      segment_size: 31'd50, has_segment: 1'b1, last: 1'b1, ended: 1'b0};
   localparam rsap_pkg::result_type ZERO_AT_HEAD = '{part_id: '0, local_offset: '0,
      segment_size: '0, has_segment: 1'b1, last: 1'b1, ended: 1'b0};

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_RANGE,
      ROW_COUNT
   } row_kind_type;

   // For loads a is the entry and b the value, for ranges a is the offset
   // and b the size, for a count row a is the new part_count.
   typedef struct {
      row_kind_type         kind;
      logic [30:0]          a;
      logic [30:0]          b;
      bit                   typed;
      rsap_pkg::result_type want;
   } plan_row_type;

   plan_row_type plan [20] = '{
      '{ROW_RANGE, 31'd5,       31'd10,    1'b1, EMPTY_ANSWER},
      '{ROW_LOAD,  31'd0,       31'd100,   1'b0, '0},
      '{ROW_LOAD,  31'd1,       31'd100,   1'b0, '0},
      '{ROW_LOAD,  31'd2,       31'd250,   1'b0, '0},
      '{ROW_LOAD,  31'd3,       TOP_VALUE, 1'b0, '0},
      '{ROW_COUNT, 31'd4,       31'd0,     1'b0, '0},
      '{ROW_RANGE, 31'd0,       31'd50,    1'b1, FIRST_FIFTY},
      '{ROW_RANGE, 31'd50,      31'd100,   1'b0, '0},
      '{ROW_RANGE, 31'd150,     TOP_VALUE, 1'b0, '0},
      '{ROW_RANGE, TOP_VALUE,   TOP_VALUE, 1'b1, EMPTY_ANSWER},
      '{ROW_RANGE, 31'd0,       31'd0,     1'b1, ZERO_AT_HEAD},
      '{ROW_RANGE, 31'd100,     31'd0,     1'b0, '0},
      '{ROW_LOAD,  31'd0,       31'd10,    1'b0, '0},
      '{ROW_LOAD,  31'd1,       31'd5,     1'b0, '0},
      '{ROW_LOAD,  31'd2,       31'd500,   1'b0, '0},
      '{ROW_COUNT, 31'd3,       31'd0,     1'b0, '0},
      '{ROW_RANGE, 31'd0,       31'd400,   1'b0, '0},
      // Entry one now lies above the resume point, so the offset wraps.
      '{ROW_LOAD,  31'd1,       31'd450,   1'b0, '0},
      '{ROW_RANGE, 31'd400,     31'd10,    1'b0, '0},
      '{ROW_RANGE, 31'h1234567, 31'd0,     1'b1, EMPTY_ANSWER}
   };

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [rsap_pkg::REQ_TDATA_W-1:0]  req_tdata   = '0;
   logic                              req_tuser   = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [rsap_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [2:0]                        csr_paddr   = '0;
   logic [31:0]                       csr_pwdata  = '0;
   logic [31:0]                       csr_prdata;
   logic                              csr_pready;

   // Local copy of the block state for prediction.
   logic [30:0] bound_tbl [rsap_pkg::TABLE_LIMIT];
   logic [3:0]  resume_part    = '0;
   logic [31:0] last_end       = '0;
   logic [4:0]  part_count_now = '0;

   rsap_pkg::result_type fresh_segments [$];
   rsap_pkg::result_type expected_segments [$];

   int          errors        = 0;
   int          send_idle_pct = 30;
   int          recv_idle_pct = 54;
   logic        hold_req      = 1'b0;
   logic        hold_on       = 1'b0;

   range_split_across_partitions dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Walks the table for one range item and leaves its segments in
   // fresh_segments, updating the resume point and the previous end.
   function automatic void split_range(input logic [30:0] off, input logic [30:0] sz);
      logic [31:0]          start;
      logic [31:0]          stop;
      logic [31:0]          b;
      logic [31:0]          loff;
      logic [31:0]          span;
      int                   n;
      int                   i;
      bit                   ended;
      rsap_pkg::result_type seg;
      fresh_segments.delete();
      start = {1'b0, off};
      stop  = {1'b0, off} + {1'b0, sz};
      n = (int'(part_count_now) > rsap_pkg::TABLE_LIMIT) ? rsap_pkg::TABLE_LIMIT
                                                          : int'(part_count_now);
      i = (start >= last_end) ? int'(resume_part) : 0;
      while (i < n) begin
         b = {1'b0, bound_tbl[i]};
         if (start < b) begin
            loff = (i > 0) ? start - {1'b0, bound_tbl[i-1]} : start;
            seg = '0;
            seg.part_id = 4'(i);
            seg.local_offset = loff[30:0];
            seg.has_segment = 1'b1;
            if (stop <= b) begin
               span = stop - start;
               seg.segment_size = span[30:0];
               fresh_segments = {fresh_segments, seg};
               resume_part = 4'(i);
               break;
            end
            span = b - start;
            seg.segment_size = span[30:0];
            fresh_segments = {fresh_segments, seg};
            start = b;
         end
         i++;
      end
      last_end = stop;
      ended = (n > 0) && (stop >= {1'b0, bound_tbl[n-1]});
      if (fresh_segments.size() == 0) begin
         fresh_segments = {fresh_segments, EMPTY_ANSWER};
      end else begin
         foreach (fresh_segments[k]) fresh_segments[k].ended = ended;
         fresh_segments[fresh_segments.size()-1].last = 1'b1;
      end
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endfunction

   // Offers one item, waits for it to be taken and updates the prediction.
   // A typed expectation replaces the predicted one for that item.
   task automatic offer_item(input rsap_pkg::req_kind_type kind, input logic [3:0] idx,
                             input logic [30:0] val, input logic [30:0] off,
                             input logic [30:0] sz, input bit typed,
                             input rsap_pkg::result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, sz, off, val, idx};
      do @(posedge clock); while (!req_tready);
      if (kind == rsap_pkg::REQ_LOAD) begin
         bound_tbl[idx] = val;
      end else begin
         split_range(off, sz);
         if (typed) expected_segments = {expected_segments, want};
         else expected_segments = {expected_segments, fresh_segments};
      end
   endtask

   // Loads carry no result, so a fixed pause follows the last expected one.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_part_count(input logic [4:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PART_COUNT_ADDR;
      csr_pwdata  <= {27'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      part_count_now = value;
   endtask

   task automatic fill_table(input bit ordered);
      logic [31:0] acc;
      logic [30:0] val;
      acc = '0;
      for (int idx = 0; idx < rsap_pkg::TABLE_LIMIT; idx++) begin
         if (ordered) begin
            acc += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1 << 26)
                                               : $urandom_range(0, 64);
            if (acc > {1'b0, TOP_VALUE}) acc = {1'b0, TOP_VALUE};
            val = acc[30:0];
            if (idx == rsap_pkg::TABLE_LIMIT - 1 && $urandom_range(0, 1) == 1) begin
               val = TOP_VALUE;
            end
         end else begin
            val = 31'($urandom_range(0, 2000));
         end
         offer_item(rsap_pkg::REQ_LOAD, 4'(idx), val, 31'($urandom), 31'($urandom),
                    1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      rsap_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_segments.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, got %h/%b/%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = expected_segments.pop_front();
            check_field("part_id", 32'(want.part_id), 32'(rsp_tdata[3:0]));
            check_field("local_offset", 32'(want.local_offset), 32'(rsp_tdata[34:4]));
            check_field("segment_size", 32'(want.segment_size), 32'(rsp_tdata[65:35]));
            check_field("ended", 32'(want.ended), 32'(rsp_tdata[66]));
            check_field("has_segment", 32'(want.has_segment), 32'(rsp_tuser));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
      if (hold_on) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // The long receiver hold-off, counted while the sender keeps offering items.
   initial begin
      wait (hold_req);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int          used;
      int          roll;
      logic [31:0] top;
      logic [30:0] off;
      logic [30:0] sz;
      logic [3:0]  pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         case (plan[r].kind)
            ROW_COUNT: begin
               wait_drained();
               write_part_count(plan[r].a[4:0]);
            end
            ROW_LOAD: begin
               offer_item(rsap_pkg::REQ_LOAD, plan[r].a[3:0], plan[r].b, 31'($urandom),
                          31'($urandom), 1'b0, '0);
            end
            default: begin
               offer_item(rsap_pkg::REQ_RANGE, 4'($urandom), 31'($urandom), plan[r].a,
                          plan[r].b, plan[r].typed, plan[r].want);
            end
         endcase
      end

      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         send_idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 54 : 0;
         recv_idle_pct <= (phase == 0) ? 54 : (phase == 1) ? 30 : 0;
         fill_table(phase != 1);
         wait_drained();
         // The last phase uses an oversized count, which the block limits.
         write_part_count((phase == 0) ? 5'd16 : (phase == 1) ? 5'($urandom_range(1, 15))
                                                               : 5'd31);
         if (phase == 2) hold_req <= 1'b1;

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            used = (int'(part_count_now) > rsap_pkg::TABLE_LIMIT) ? rsap_pkg::TABLE_LIMIT
                                                                   : int'(part_count_now);
            top  = (used == 0) ? 32'd0 : {1'b0, bound_tbl[used-1]};
            if ($urandom_range(0, 99) < 8) begin
               pick = 4'($urandom_range(0, 15));
               offer_item(rsap_pkg::REQ_LOAD, pick,
                          ($urandom_range(0, 3) == 0) ? 31'($urandom) : bound_tbl[pick],
                          31'($urandom), 31'($urandom), 1'b0, '0);
            end else begin
               // Mostly continuations and offsets inside the table.
               roll = $urandom_range(0, 99);
               if (roll < 45 && !last_end[31]) off = last_end[30:0];
               else if (roll < 80) off = 31'($urandom_range(0, top + 16));
               else if (roll < 90) off = 31'($urandom);
               else off = '0;
               roll = $urandom_range(0, 99);
               if (roll < 50) sz = 31'($urandom_range(0, 128));
               else if (roll < 80) sz = 31'($urandom_range(0, top));
               else if (roll < 90) sz = '0;
               else sz = 31'($urandom);
               offer_item(rsap_pkg::REQ_RANGE, 4'($urandom), 31'($urandom), off, sz,
                          1'b0, '0);
            end
         end
      end

      wait_drained();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
